FILE: hw/rtl/char_lcd_nibble_interface_unit_macros.svh
// Assertion macros for the RTL of the character LCD interface, included by clniu_back.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLNIU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLNIU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/clniu_pkg.sv
`default_nettype none

package clniu_pkg;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned COLUMN_W   = 6;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned HOLD_W     = 17;
  localparam int unsigned EH_W       = 10;
  localparam int unsigned SETTLE_W   = 14;
  localparam int unsigned SHORT_W    = 14;
  localparam int unsigned LONG_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned STEP_W     = 5;

  localparam logic [HOLD_W-1:0]   HOLD_MAX       = 17'd131071;
  localparam logic [EH_W-1:0]     EH_RESET       = 10'd2;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 14'd50;
  localparam logic [SHORT_W-1:0]  SHORT_RESET    = 14'd50;
  localparam logic [LONG_W-1:0]   LONG_RESET     = 17'd2000;
  localparam logic [HOLD_W-1:0]   POWER_SOFT_US  = 17'd50000;
  localparam logic [HOLD_W-1:0]   POWER_HARD1_US = 17'd20000;
  localparam logic [HOLD_W-1:0]   POWER_HARD2_US = 17'd80000;
  localparam logic [HOLD_W-1:0]   WAKE_LONG_US   = 17'd4500;
  localparam logic [HOLD_W-1:0]   WAKE_SHORT_US  = 17'd150;
  localparam logic [HOLD_W-1:0]   FINAL_WAIT_US  = 17'd2000;

  localparam logic [VALUE_W-1:0] CMD_CLEAR = 8'h01;
  localparam logic [VALUE_W-1:0] CMD_HOME  = 8'h02;

  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd3;
  localparam logic [STEP_W-1:0] SOFT_FIRST_STEP = 5'd1;
  localparam logic [STEP_W-1:0] HARD_FIRST_STEP = 5'd0;
  localparam logic [STEP_W-1:0] INIT_BODY_STEP  = 5'd2;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd29;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CMD       = 3'd0,
    OP_DATA      = 3'd1,
    OP_CURSOR    = 3'd2,
    OP_SOFT_INIT = 3'd3,
    OP_HARD_INIT = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_HIGH   = 2'd0,
    CFG_NIBBLE_SETTLE = 2'd1,
    CFG_SHORT_WAIT    = 2'd2,
    CFG_LONG_WAIT     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_DATA,
    JOB_SOFT,
    JOB_HARD
  } job_e;

  typedef enum logic [3:0] {
    EXTRA_NONE,
    EXTRA_WAKE_LONG,
    EXTRA_WAKE_SHORT,
    EXTRA_SHORT,
    EXTRA_LONG,
    EXTRA_SHORT_FINAL,
    EXTRA_POWER_SOFT,
    EXTRA_POWER_HARD1,
    EXTRA_POWER_HARD2
  } extra_e;

  typedef enum logic [1:0] {
    HOLD_ENABLE,
    HOLD_SETTLE,
    HOLD_FIXED
  } hold_e;

  typedef struct packed {
    job_e               kind;
    logic               long_wait;
    logic [VALUE_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic [EH_W-1:0]     enable_high;
    logic [SETTLE_W-1:0] settle;
    logic [SHORT_W-1:0]  short_wait;
    logic [LONG_W-1:0]   long_wait;
  } cfg_t;

  typedef struct packed {
    logic                rs;
    logic                en;
    logic [NIBBLE_W-1:0] nibble;
    logic [HOLD_W-1:0]   hold;
    logic                last;
  } seg_t;

  typedef struct packed {
    logic [NIBBLE_W-1:0] nibble;
    extra_e              extra;
  } init_nib_t;

  // Nibble sends of the init body: wake-up nibbles, then five set-up commands.
  function automatic init_nib_t init_nibble(input logic [3:0] idx);
    init_nib_t r;
    unique case (idx)
      4'd0:    r = '{nibble: 4'h3, extra: EXTRA_WAKE_LONG};
      4'd1:    r = '{nibble: 4'h3, extra: EXTRA_WAKE_LONG};
      4'd2:    r = '{nibble: 4'h3, extra: EXTRA_WAKE_SHORT};
      4'd3:    r = '{nibble: 4'h2, extra: EXTRA_WAKE_SHORT};
      4'd4:    r = '{nibble: 4'h2, extra: EXTRA_NONE};
      4'd5:    r = '{nibble: 4'h8, extra: EXTRA_SHORT};
      4'd6:    r = '{nibble: 4'h0, extra: EXTRA_NONE};
      4'd7:    r = '{nibble: 4'h8, extra: EXTRA_SHORT};
      4'd8:    r = '{nibble: 4'h0, extra: EXTRA_NONE};
      4'd9:    r = '{nibble: 4'h1, extra: EXTRA_LONG};
      4'd10:   r = '{nibble: 4'h0, extra: EXTRA_NONE};
      4'd11:   r = '{nibble: 4'h6, extra: EXTRA_SHORT};
      4'd12:   r = '{nibble: 4'h0, extra: EXTRA_NONE};
      4'd13:   r = '{nibble: 4'hC, extra: EXTRA_SHORT_FINAL};
      default: r = '{nibble: 4'h0, extra: EXTRA_NONE};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/clniu_front.sv
`default_nettype none

module clniu_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [clniu_pkg::OPCODE_W-1:0] opcode_i,
  input  wire logic [clniu_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [clniu_pkg::COLUMN_W-1:0] column_i,
  input  wire logic                           row_i,
  output logic                                job_valid_o,
  output clniu_pkg::job_t                     job_o,
  input  wire logic                           job_pop_i
);
  import clniu_pkg::*;

  job_t       job_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  job_t       job_in;
  logic       known;
  logic       accept;
  logic       wr_en;
  logic       rd_en;

  always_comb begin
    job_in = '{kind: JOB_CMD, long_wait: 1'b0, value: value_i};
    known  = 1'b1;
    unique case (op_e'(opcode_i))
      OP_CMD: begin
        job_in.long_wait = (value_i == CMD_CLEAR) || (value_i == CMD_HOME);
      end
      OP_DATA: begin
        job_in.kind = JOB_DATA;
      end
      OP_CURSOR: begin
        job_in.value = {1'b1, row_i, column_i};
      end
      OP_SOFT_INIT: begin
        job_in.kind = JOB_SOFT;
      end
      OP_HARD_INIT: begin
        job_in.kind = JOB_HARD;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign wr_en       = accept && known;
  assign job_valid_o = (cnt_q != 2'd0);
  assign rd_en       = job_pop_i && job_valid_o;
  assign job_o       = job_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      job_mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/clniu_back.sv
`default_nettype none
`include "char_lcd_nibble_interface_unit_macros.svh"

module clniu_back (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire clniu_pkg::cfg_t cfg_i,
  input  wire logic  job_valid_i,
  input  wire clniu_pkg::job_t job_i,
  output logic       job_pop_o,
  output logic       out_push_o,
  output clniu_pkg::seg_t out_seg_o,
  input  wire logic  out_full_i
);
  import clniu_pkg::*;

  typedef struct packed {
    logic                rs;
    logic                en;
    logic [NIBBLE_W-1:0] nibble;
    hold_e               hsel;
    extra_e              extra;
    logic                last;
  } seg_req_t;

  typedef struct packed {
    logic                rs;
    logic                en;
    logic [NIBBLE_W-1:0] nibble;
    hold_e               hsel;
    logic [HOLD_W-1:0]   extra;
    logic                last;
  } stage_t;

  logic                busy_q, busy_d;
  job_t                job_q, job_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                held_rs_q, held_rs_d;
  logic [NIBBLE_W-1:0] held_nib_q, held_nib_d;
  logic                stg_v_q, stg_v_d;
  stage_t              stg_q, stg_d;

  seg_req_t            req;
  logic [STEP_W-1:0]   body_step;
  init_nib_t           ent;
  logic [HOLD_W-1:0]   extra_val;
  logic                stg_ready;
  logic                issue;
  logic [HOLD_W:0]     settle_sum;

  assign body_step = cnt_q - INIT_BODY_STEP;
  assign ent       = init_nibble(body_step[4:1]);

  always_comb begin
    req = '{rs: 1'b0, en: 1'b0, nibble: '0, hsel: HOLD_ENABLE, extra: EXTRA_NONE,
            last: 1'b0};
    unique case (job_q.kind) inside
      JOB_CMD, JOB_DATA: begin
        req.rs     = (job_q.kind == JOB_DATA);
        req.en     = !cnt_q[0];
        req.nibble = cnt_q[1] ? job_q.value[3:0] : job_q.value[7:4];
        req.hsel   = cnt_q[0] ? HOLD_SETTLE : HOLD_ENABLE;
        if (cnt_q[1] && (job_q.kind == JOB_CMD)) begin
          req.extra = job_q.long_wait ? EXTRA_LONG : EXTRA_SHORT;
        end
        req.last = (cnt_q == BYTE_LAST_STEP);
      end
      JOB_SOFT, JOB_HARD: begin
        if (cnt_q == HARD_FIRST_STEP) begin
          req.rs     = held_rs_q;
          req.nibble = held_nib_q;
          req.hsel   = HOLD_FIXED;
          req.extra  = EXTRA_POWER_HARD1;
        end else if (cnt_q == SOFT_FIRST_STEP) begin
          req.hsel = HOLD_FIXED;
          if (job_q.kind == JOB_SOFT) begin
            req.rs     = held_rs_q;
            req.nibble = held_nib_q;
            req.extra  = EXTRA_POWER_SOFT;
          end else begin
            req.extra = EXTRA_POWER_HARD2;
          end
        end else begin
          req.en     = !body_step[0];
          req.nibble = ent.nibble;
          req.hsel   = body_step[0] ? HOLD_SETTLE : HOLD_ENABLE;
          req.extra  = body_step[0] ? ent.extra : EXTRA_NONE;
        end
        req.last = (cnt_q == INIT_LAST_STEP);
      end
      default: begin
        req.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (req.extra)
      EXTRA_NONE:        extra_val = '0;
      EXTRA_WAKE_LONG:   extra_val = WAKE_LONG_US;
      EXTRA_WAKE_SHORT:  extra_val = WAKE_SHORT_US;
      EXTRA_SHORT:       extra_val = HOLD_W'(cfg_i.short_wait);
      EXTRA_LONG:        extra_val = cfg_i.long_wait;
      EXTRA_SHORT_FINAL: extra_val = HOLD_W'(cfg_i.short_wait) + FINAL_WAIT_US;
      EXTRA_POWER_SOFT:  extra_val = POWER_SOFT_US;
      EXTRA_POWER_HARD1: extra_val = POWER_HARD1_US;
      EXTRA_POWER_HARD2: extra_val = POWER_HARD2_US;
      default:           extra_val = '0;
    endcase
  end

  assign stg_ready = !stg_v_q || !out_full_i;
  assign issue     = busy_q && stg_ready;
  assign job_pop_o = job_valid_i && (!busy_q || (issue && req.last));

  always_comb begin
    busy_d     = busy_q;
    job_d      = job_q;
    cnt_d      = cnt_q;
    held_rs_d  = held_rs_q;
    held_nib_d = held_nib_q;
    stg_v_d    = stg_v_q;
    stg_d      = stg_q;
    if (issue) begin
      held_rs_d  = req.rs;
      held_nib_d = req.nibble;
      cnt_d      = cnt_q + 5'd1;
      if (req.last) begin
        busy_d = 1'b0;
      end
    end
    if (job_pop_o) begin
      busy_d = 1'b1;
      job_d  = job_i;
      cnt_d  = (job_i.kind == JOB_SOFT) ? SOFT_FIRST_STEP : HARD_FIRST_STEP;
    end
    if (stg_ready) begin
      stg_v_d = issue;
      stg_d   = '{rs: req.rs, en: req.en, nibble: req.nibble, hsel: req.hsel,
                  extra: extra_val, last: req.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      held_rs_q  <= 1'b0;
      held_nib_q <= '0;
      stg_v_q    <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      held_rs_q  <= held_rs_d;
      held_nib_q <= held_nib_d;
      stg_v_q    <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    stg_q <= stg_d;
  end

  assign settle_sum = (HOLD_W + 1)'(cfg_i.settle) + (HOLD_W + 1)'(stg_q.extra);

  always_comb begin
    out_seg_o = '{rs: stg_q.rs, en: stg_q.en, nibble: stg_q.nibble, hold: stg_q.extra,
                  last: stg_q.last};
    unique case (stg_q.hsel)
      HOLD_ENABLE: out_seg_o.hold = HOLD_W'(cfg_i.enable_high);
      HOLD_SETTLE: out_seg_o.hold = settle_sum[HOLD_W] ? HOLD_MAX : settle_sum[HOLD_W-1:0];
      default:     out_seg_o.hold = stg_q.extra;
    endcase
  end

  assign out_push_o = stg_v_q && !out_full_i;

  `CLNIU_ASSERT_IMP(a_step_range, busy_q, cnt_q <= INIT_LAST_STEP, "step past init end")
  `CLNIU_ASSERT_IMP(a_byte_range, busy_q && (job_q.kind == JOB_CMD || job_q.kind == JOB_DATA),
                    cnt_q <= BYTE_LAST_STEP, "byte transaction past four segments")
  `CLNIU_ASSERT_NEXT(a_stage_hold, stg_v_q && out_full_i, stg_v_q && $stable(stg_q),
                     "stage segment lost while output queue full")
  `CLNIU_ASSERT_NEXT(a_done_idle, issue && req.last && !job_valid_i, !busy_q,
                     "sequencer still busy after final segment")

endmodule

`default_nettype wire

FILE: hw/rtl/clniu_out_queue.sv
`default_nettype none

module clniu_out_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire clniu_pkg::seg_t seg_i,
  output logic            full_o,
  output logic            empty,
  input  wire logic       pop,
  output clniu_pkg::seg_t seg_o
);
  import clniu_pkg::*;

  seg_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en;
  logic       rd_en;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign wr_en  = push_i && !full_o;
  assign rd_en  = pop && !empty;
  assign seg_o  = mem_q[rd_ptr_q];
  assign cnt_d  = cnt_q + 2'(wr_en) - 2'(rd_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ wr_en;
      rd_ptr_q <= rd_ptr_q ^ rd_en;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= seg_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_interface_unit.sv
// Character LCD driver for a 4-bit bus. Each request (command byte, data byte, set cursor,
// soft init, hard init) is turned into timed pin segments, one segment per cycle from a single
// sequencer while the output queue has room: a byte is four segments, a soft init 29 and a hard
// init 30, and the segments of the next request follow without a gap. Requests are taken one
// per cycle while the two-entry request queue has room; results wait in a two-entry queue read
// through empty and pop. Register writes are applied at once and belong only in idle periods.
`default_nettype none

module char_lcd_nibble_interface_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [clniu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [clniu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [clniu_pkg::OPCODE_W-1:0]   opcode_i,
  input  wire logic [clniu_pkg::VALUE_W-1:0]    value_i,
  input  wire logic [clniu_pkg::COLUMN_W-1:0]   column_i,
  input  wire logic                             row_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic                                  rs_level_o,
  output logic                                  enable_level_o,
  output logic [clniu_pkg::NIBBLE_W-1:0]        nibble_o,
  output logic [clniu_pkg::HOLD_W-1:0]          hold_us_o,
  output logic                                  last_o
);
  import clniu_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic job_valid;
  job_t job;
  logic job_pop;
  logic out_push;
  seg_t out_seg;
  logic out_full;
  seg_t head_seg;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE_HIGH:   cfg_d.enable_high = cfg_data_i[EH_W-1:0];
        CFG_NIBBLE_SETTLE: cfg_d.settle      = cfg_data_i[SETTLE_W-1:0];
        CFG_SHORT_WAIT:    cfg_d.short_wait  = cfg_data_i[SHORT_W-1:0];
        CFG_LONG_WAIT:     cfg_d.long_wait   = cfg_data_i[LONG_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable_high: EH_RESET, settle: SETTLE_RESET, short_wait: SHORT_RESET,
                 long_wait: LONG_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clniu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  clniu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_push_o  (out_push),
    .out_seg_o   (out_seg),
    .out_full_i  (out_full)
  );

  clniu_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .seg_i  (out_seg),
    .full_o (out_full),
    .empty  (empty),
    .pop    (pop),
    .seg_o  (head_seg)
  );

  assign rs_level_o     = head_seg.rs;
  assign enable_level_o = head_seg.en;
  assign nibble_o       = head_seg.nibble;
  assign hold_us_o      = head_seg.hold;
  assign last_o         = head_seg.last;

endmodule

`default_nettype wire

FILE: test/char_lcd_nibble_interface_unit_tb.sv
`default_nettype none

module char_lcd_nibble_interface_unit_tb;
  import clniu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned REQUESTS_PER_PHASE = 70;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam int unsigned EH_HIGH = 1000;
  localparam int unsigned SETTLE_HIGH = 10000;
  localparam int unsigned SHORT_HIGH = 10000;
  localparam int unsigned LONG_HIGH = 100000;
  localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

  localparam logic [VALUE_W-1:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [VALUE_W-1:0] CMD_DISPLAY_OFF = 8'h08;
  localparam logic [VALUE_W-1:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [VALUE_W-1:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [VALUE_W-1:0] CMD_SET_ADDRESS = 8'h80;
  localparam logic [VALUE_W-1:0] ROW1_ADDRESS = 8'h40;
  localparam logic [VALUE_W-1:0] ADDRESS_MASK = 8'h7F;
  localparam logic [NIBBLE_W-1:0] WAKE_NIBBLE = 4'h3;
  localparam logic [NIBBLE_W-1:0] FOUR_BIT_NIBBLE = 4'h2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  logic [OPCODE_W-1:0]   opcode_i;
  logic [VALUE_W-1:0]    value_i;
  logic [COLUMN_W-1:0]   column_i;
  logic                  row_i;
  logic                  empty;
  logic                  pop;
  logic                  rs_level_o;
  logic                  enable_level_o;
  logic [NIBBLE_W-1:0]   nibble_o;
  logic [HOLD_W-1:0]     hold_us_o;
  logic                  last_o;

  logic [EH_W-1:0]     enable_high_us;
  logic [SETTLE_W-1:0] settle_us;
  logic [SHORT_W-1:0]  short_wait_us;
  logic [LONG_W-1:0]   long_wait_us;
  logic                held_rs;
  logic [NIBBLE_W-1:0] held_nibble;

  seg_t        expected_segments[$];
  seg_t        staged_segment;
  bit          segment_staged;
  seg_t        observed_segment;
  seg_t        wanted_segment;
  bit          steady;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  char_lcd_nibble_interface_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .empty          (empty),
    .pop            (pop),
    .rs_level_o     (rs_level_o),
    .enable_level_o (enable_level_o),
    .nibble_o       (nibble_o),
    .hold_us_o      (hold_us_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("char_lcd_nibble_interface_unit: mismatch");
    $finish;
  end

  function automatic logic [HOLD_W-1:0] clamp_hold(input int unsigned us);
    return (us > HOLD_MAX) ? HOLD_MAX : us[HOLD_W-1:0];
  endfunction

  // The previous segment is held back so that the final one of a request can carry last.
  function automatic void emit_segment(input logic rs, input logic en,
                                       input logic [NIBBLE_W-1:0] nib,
                                       input logic [HOLD_W-1:0] hold);
    if (segment_staged) expected_segments.push_back(staged_segment);
    staged_segment = '{rs: rs, en: en, nibble: nib, hold: hold, last: 1'b0};
    segment_staged = 1'b1;
    held_rs = rs;
    held_nibble = nib;
  endfunction

  function automatic void lcd_nibble(input logic rs, input logic [NIBBLE_W-1:0] nib,
                                     input int unsigned extra_us);
    emit_segment(rs, 1'b1, nib, HOLD_W'(enable_high_us));
    emit_segment(rs, 1'b0, nib, clamp_hold(settle_us + extra_us));
  endfunction

  function automatic void lcd_byte(input logic rs, input logic [VALUE_W-1:0] b,
                                   input int unsigned extra_us);
    lcd_nibble(rs, b[7:4], 0);
    lcd_nibble(rs, b[3:0], extra_us);
  endfunction

  function automatic void lcd_command(input logic [VALUE_W-1:0] c, input int unsigned extra_us);
    int unsigned pause_us;
    pause_us = (c == CMD_CLEAR || c == CMD_HOME) ? long_wait_us : short_wait_us;
    lcd_byte(1'b0, c, clamp_hold(pause_us + extra_us));
  endfunction

  function automatic void power_up_sequence();
    lcd_nibble(1'b0, WAKE_NIBBLE, WAKE_LONG_US);
    lcd_nibble(1'b0, WAKE_NIBBLE, WAKE_LONG_US);
    lcd_nibble(1'b0, WAKE_NIBBLE, WAKE_SHORT_US);
    lcd_nibble(1'b0, FOUR_BIT_NIBBLE, WAKE_SHORT_US);
    lcd_command(CMD_FUNCTION_SET, 0);
    lcd_command(CMD_DISPLAY_OFF, 0);
    lcd_command(CMD_CLEAR, 0);
    lcd_command(CMD_ENTRY_MODE, 0);
    lcd_command(CMD_DISPLAY_ON, FINAL_WAIT_US);
  endfunction

  function automatic void predict_segments(input logic [OPCODE_W-1:0] op,
                                           input logic [VALUE_W-1:0] value,
                                           input logic [COLUMN_W-1:0] column,
                                           input logic row);
    segment_staged = 1'b0;
    case (op)
      OP_CMD: lcd_command(value, 0);
      OP_DATA: lcd_byte(1'b1, value, 0);
      OP_CURSOR: begin
        lcd_command(CMD_SET_ADDRESS | (((row ? ROW1_ADDRESS : 8'h00) + column) & ADDRESS_MASK), 0);
      end
      OP_SOFT_INIT: begin
        emit_segment(held_rs, 1'b0, held_nibble, POWER_SOFT_US);
        power_up_sequence();
      end
      OP_HARD_INIT: begin
        emit_segment(held_rs, 1'b0, held_nibble, POWER_HARD1_US);
        emit_segment(1'b0, 1'b0, 4'h0, POWER_HARD2_US);
        power_up_sequence();
      end
      default: ;
    endcase
    if (segment_staged) begin
      staged_segment.last = 1'b1;
      expected_segments.push_back(staged_segment);
    end
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    if ($urandom_range(0, 2) != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(input string what, input seg_t want, input seg_t got);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $write("%s: expected rs=%0d en=%0d nibble=%h hold=%0d last=%0d",
             what, want.rs, want.en, want.nibble, want.hold, want.last);
      $display(", got rs=%0d en=%0d nibble=%h hold=%0d last=%0d",
               got.rs, got.en, got.nibble, got.hold, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      observed_segment = '{rs_level_o, enable_level_o, nibble_o, hold_us_o, last_o};
      if (expected_segments.size() == 0) begin
        report_mismatch("segment transaction with nothing expected", '0, observed_segment);
      end else begin
        wanted_segment = expected_segments.pop_front();
        if (observed_segment !== wanted_segment) begin
          report_mismatch("segment mismatch", wanted_segment, observed_segment);
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    pop = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !steady) stall = next_gap();
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value,
                              input logic [COLUMN_W-1:0] column, input logic row);
    int unsigned gap;
    gap = steady ? 0 : next_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    value_i <= value;
    column_i <= column;
    row_i <= row;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_segments(op, value, column, row);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    push <= 1'b0;
    while (expected_segments.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ENABLE_HIGH: enable_high_us = data[EH_W-1:0];
      CFG_NIBBLE_SETTLE: settle_us = data[SETTLE_W-1:0];
      CFG_SHORT_WAIT: short_wait_us = data[SHORT_W-1:0];
      CFG_LONG_WAIT: long_wait_us = data[LONG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] eh, input logic [CFG_DATA_W-1:0] settle,
                               input logic [CFG_DATA_W-1:0] short_us,
                               input logic [CFG_DATA_W-1:0] long_us);
    write_register(CFG_ENABLE_HIGH, eh);
    write_register(CFG_NIBBLE_SETTLE, settle);
    write_register(CFG_SHORT_WAIT, short_us);
    write_register(CFG_LONG_WAIT, long_us);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned lo,
                                                         input int unsigned hi);
    case ($urandom_range(0, 5))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      2: return CFG_DATA_W'($urandom_range(0, CFG_ALL_ONES));
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic test_reset_values();
    send_request(OP_SOFT_INIT, 8'h00, 6'd0, 1'b0);
    send_request(OP_DATA, 8'hA5, 6'd0, 1'b0);
    send_request(OP_UNUSED_LO, 8'hFF, 6'd63, 1'b1);
    send_request(OP_SOFT_INIT, 8'hFF, 6'd63, 1'b1);
    send_request(OP_HARD_INIT, 8'h00, 6'd0, 1'b0);
    send_request(OP_CMD, CMD_CLEAR, 6'd0, 1'b0);
    send_request(OP_CMD, CMD_HOME, 6'd0, 1'b0);
    send_request(OP_CMD, 8'h00, 6'd0, 1'b0);
    send_request(OP_CMD, 8'hFF, 6'd0, 1'b0);
    send_request(OP_DATA, 8'h00, 6'd0, 1'b0);
    send_request(OP_DATA, 8'hFF, 6'd0, 1'b0);
    send_request(OP_CURSOR, 8'h00, 6'd0, 1'b0);
    send_request(OP_CURSOR, 8'h00, 6'd39, 1'b1);
    send_request(OP_CURSOR, 8'h00, 6'd63, 1'b1);
    send_request(OP_UNUSED_MID, 8'h5A, 6'd21, 1'b0);
    send_request(OP_UNUSED_HI, 8'hC3, 6'd42, 1'b1);
  endtask

  task automatic test_register_extremes();
    drain_pipeline();
    set_registers(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
    send_request(OP_CMD, CMD_HOME, 6'd0, 1'b0);
    send_request(OP_DATA, 8'h5A, 6'd0, 1'b0);
    send_request(OP_HARD_INIT, 8'h00, 6'd0, 1'b0);
    drain_pipeline();
    set_registers('0, '0, '0, '0);
    send_request(OP_CMD, CMD_CLEAR, 6'd0, 1'b0);
    send_request(OP_CURSOR, 8'h00, 6'd21, 1'b0);
    send_request(OP_SOFT_INIT, 8'h00, 6'd0, 1'b0);
    drain_pipeline();
    set_registers(CFG_DATA_W'(EH_HIGH), CFG_DATA_W'(SETTLE_HIGH), CFG_DATA_W'(SHORT_HIGH),
                  CFG_DATA_W'(LONG_HIGH));
    send_request(OP_CMD, 8'h33, 6'd0, 1'b0);
    send_request(OP_DATA, 8'hC3, 6'd0, 1'b0);
    send_request(OP_HARD_INIT, 8'h00, 6'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned issued;
    int unsigned pick;
    logic [VALUE_W-1:0] value;
    logic [COLUMN_W-1:0] column;
    logic row;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      set_registers(pick_setting(1, EH_HIGH), pick_setting(1, SETTLE_HIGH),
                    pick_setting(0, SHORT_HIGH), pick_setting(0, LONG_HIGH));
      steady = (phase % 3 == 2);
      issued = 0;
      while (issued < REQUESTS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        value = VALUE_W'($urandom_range(0, 255));
        column = COLUMN_W'($urandom_range(0, 63));
        row = 1'($urandom_range(0, 1));
        if (pick < 5) begin
          send_request(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), value, column,
                       row);
        end else begin
          issued++;
          if (pick < 45) begin
            if ($urandom_range(0, 3) == 0) value = VALUE_W'($urandom_range(CMD_CLEAR, CMD_HOME));
            send_request(OP_CMD, value, column, row);
          end else if (pick < 75) begin
            send_request(OP_DATA, value, column, row);
          end else if (pick < 91) begin
            if ($urandom_range(0, 4) != 0) column = COLUMN_W'($urandom_range(0, 39));
            send_request(OP_CURSOR, value, column, row);
          end else if (pick < 96) begin
            send_request(OP_SOFT_INIT, value, column, row);
          end else begin
            send_request(OP_HARD_INIT, value, column, row);
          end
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ENABLE_HIGH;
    cfg_data_i = '0;
    opcode_i = OP_CMD;
    value_i = '0;
    column_i = '0;
    row_i = 1'b0;
    steady = 1'b0;
    segment_staged = 1'b0;
    enable_high_us = EH_RESET;
    settle_us = SETTLE_RESET;
    short_wait_us = SHORT_RESET;
    long_wait_us = LONG_RESET;
    held_rs = 1'b0;
    held_nibble = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_register_extremes();
    test_random_traffic();
    drain_pipeline();
    if (expected_segments.size() != 0) begin
      failures += expected_segments.size();
      $display("%0d expected segments never produced", expected_segments.size());
    end
    if (failures == 0) begin
      $display("char_lcd_nibble_interface_unit: match");
    end else begin
      $display("char_lcd_nibble_interface_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
